[src/lms_adaptive_fir_top_defines.svh]
// assertion macros for the lms adaptive fir top level
// needs a clock named clk and an active-low reset named rst_n in the including scope
`ifndef LMS_ADAPTIVE_FIR_TOP_DEFINES_SVH
`define LMS_ADAPTIVE_FIR_TOP_DEFINES_SVH

// same-cycle implication
`define LMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lms_pkg.sv]
// constants, beat types and state encoding of the lms adaptive fir
// no dependencies
`default_nettype none

package lms_pkg;

  localparam int TAPS       = 320;
  localparam int STEP_SHIFT = 24;
  localparam int W_FRAC     = 30;
  localparam int X_W        = 16;
  localparam int W_W        = 32;
  localparam int STEP_W     = 16;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd36029;

  localparam int AW    = $clog2(TAPS);
  localparam int CNT_W = $clog2(TAPS + 2);
  localparam int ACC_W = W_W + X_W + $clog2(TAPS);
  localparam int Y_W   = ACC_W - W_FRAC;
  localparam int E_W   = Y_W + 1;
  localparam int GE_W  = E_W + STEP_W + 1;
  localparam int MA_W  = (GE_W > W_W) ? GE_W : W_W;
  localparam int MB_W  = X_W + 1;
  localparam int P_W   = MA_W + MB_W;
  localparam int DL_W  = GE_W + X_W - STEP_SHIFT;
  localparam int NW_W  = ((DL_W > W_W) ? DL_W : W_W) + 1;

  localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);

  localparam logic signed [E_W-1:0] E_MAX = E_W'(32767);
  localparam logic signed [E_W-1:0] E_MIN = E_W'(-32768);
  localparam logic signed [NW_W-1:0] W_MAX = NW_W'(64'sd2147483647);
  localparam logic signed [NW_W-1:0] W_MIN = NW_W'(-64'sd2147483648);

  typedef struct packed {
    logic signed [X_W-1:0] sample_in;
    logic signed [X_W-1:0] desired_in;
  } in_t;

  typedef struct packed {
    logic signed [X_W-1:0] error_out;
    logic signed [X_W-1:0] filter_out;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_ERR,
    ST_GAIN,
    ST_UPD,
    ST_DONE
  } state_t;

  function automatic logic signed [X_W-1:0] sat16(input logic signed [E_W-1:0] v);
    logic signed [X_W-1:0] r;
    if (v > E_MAX) begin
      r = 16'sh7fff;
    end else if (v < E_MIN) begin
      r = 16'sh8000;
    end else begin
      r = v[X_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/lms_ram.sv]
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module lms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 320
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[src/lms_adaptive_fir_top.sv]
// lms adaptive fir top level: sequencer, shared multiplier, sample ring and weight store
// depends on lms_pkg, lms_ram and lms_adaptive_fir_top_defines.svh
//
// One beat in gives one beat out (error_out, filter_out). After reset the block clears
// the sample ring and the weight ram and takes no input meanwhile; configuration
// writes are taken at any time. Each item then takes one pass of the single shared
// multiplier over all taps for the filter output and one pass for the weight update,
// with the weight ram's one read and one write port setting the pace of one tap a
// cycle. in_ready is high only between items; the result waits in an output register,
// and a new item may be accepted while it is still untaken.
`default_nettype none

`include "lms_adaptive_fir_top_defines.svh"

module lms_adaptive_fir_top
  import lms_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_t               in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [STEP_W-1:0] cfg_data
);

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]            head_r, head_nxt;
  logic [AW-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic                     s1_v_r, s1_v_nxt;
  logic                     s2_v_r, s2_v_nxt;
  logic [AW-1:0]            k1_r, k1_nxt;
  logic [AW-1:0]            k2_r, k2_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_t                     out_r, out_nxt;
  logic signed [X_W-1:0]    x_r, x_nxt;
  logic signed [X_W-1:0]    d_r, d_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [Y_W-1:0]    y_r, y_nxt;
  logic signed [E_W-1:0]    e_r, e_nxt;
  logic signed [GE_W-1:0]   ge_r, ge_nxt;
  logic signed [P_W-1:0]    prod_r, prod_nxt;
  logic signed [W_W-1:0]    w2_r, w2_nxt;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [P_W-1:0]    mul_p;

  logic                     x_we, w_we;
  logic [AW-1:0]            x_waddr, w_waddr;
  logic [X_W-1:0]           x_wdata, x_rdata;
  logic [W_W-1:0]           w_wdata, w_rdata;
  logic signed [X_W-1:0]    x_rd;
  logic signed [W_W-1:0]    w_rd;
  logic signed [NW_W-1:0]   delta, nw;
  logic                     issue;
  logic                     pass_end;

  lms_ram #(.WIDTH(X_W), .DEPTH(TAPS)) u_ring (
    .clk     (clk),
    .wr_en   (x_we),
    .wr_addr (x_waddr),
    .wr_data (x_wdata),
    .rd_addr (rd_ptr_r),
    .rd_data (x_rdata)
  );

  lms_ram #(.WIDTH(W_W), .DEPTH(TAPS)) u_weights (
    .clk     (clk),
    .wr_en   (w_we),
    .wr_addr (w_waddr),
    .wr_data (w_wdata),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (w_rdata)
  );

  assign x_rd = $signed(x_rdata);
  assign w_rd = $signed(w_rdata);

  // shared multiplier
  always_comb begin
    case (state_r)
      ST_GAIN: begin
        mul_a = MA_W'(e_r);
        mul_b = $signed({1'b0, step_r});
      end
      ST_UPD: begin
        mul_a = MA_W'(ge_r);
        mul_b = MB_W'(x_rd);
      end
      default: begin
        mul_a = MA_W'(w_rd);
        mul_b = MB_W'(x_rd);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // weight update from the registered product
  always_comb begin
    delta = NW_W'(prod_r >>> STEP_SHIFT);
    nw    = NW_W'(w2_r) + delta;
  end

  assign issue    = (cnt_r < CNT_W'(TAPS));
  assign pass_end = (cnt_r == CNT_W'(TAPS + 1));

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    rd_ptr_nxt    = rd_ptr_r;
    step_nxt      = cfg_valid ? cfg_data : step_r;
    s1_v_nxt      = 1'b0;
    s2_v_nxt      = s1_v_r;
    k1_nxt        = cnt_r[AW-1:0];
    k2_nxt        = k1_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_nxt       = out_r;
    x_nxt         = x_r;
    d_nxt         = d_r;
    acc_nxt       = acc_r;
    y_nxt         = y_r;
    e_nxt         = e_r;
    ge_nxt        = ge_r;
    prod_nxt      = mul_p;
    w2_nxt        = w_rd;
    x_we          = 1'b0;
    x_waddr       = head_r;
    x_wdata       = x_r;
    w_we          = 1'b0;
    w_waddr       = k2_r;
    w_wdata       = '0;

    if (nw > W_MAX) begin
      w_wdata = W_MAX[W_W-1:0];
    end else if (nw < W_MIN) begin
      w_wdata = W_MIN[W_W-1:0];
    end else begin
      w_wdata = nw[W_W-1:0];
    end

    unique case (state_r)
      ST_CLEAR: begin
        x_we    = 1'b1;
        x_waddr = cnt_r[AW-1:0];
        x_wdata = '0;
        w_we    = 1'b1;
        w_waddr = cnt_r[AW-1:0];
        w_wdata = '0;
        if (cnt_r[AW-1:0] == LAST_ADDR) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_data.sample_in;
          d_nxt     = in_data.desired_in;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        x_we       = 1'b1;
        rd_ptr_nxt = head_r;
        head_nxt   = (head_r == LAST_ADDR) ? '0 : head_r + 1'b1;
        acc_nxt    = '0;
        cnt_nxt    = '0;
        state_nxt  = ST_MAC;
      end
      ST_MAC, ST_UPD: begin
        s1_v_nxt = issue;
        if (issue) begin
          rd_ptr_nxt = (rd_ptr_r == '0) ? LAST_ADDR : rd_ptr_r - 1'b1;
        end
        if (s2_v_r) begin
          if (state_r == ST_MAC) begin
            acc_nxt = acc_r + prod_r[ACC_W-1:0];
          end else begin
            w_we = 1'b1;
          end
        end
        if (pass_end) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_MAC) ? ST_ERR : ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ERR: begin
        y_nxt     = Y_W'(acc_r >>> W_FRAC);
        e_nxt     = E_W'(d_r) - E_W'(y_nxt);
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        ge_nxt    = GE_W'(mul_p);
        state_nxt = ST_UPD;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_nxt.error_out  = sat16(e_r);
          out_nxt.filter_out = sat16(E_W'(y_r));
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      head_r      <= '0;
      rd_ptr_r    <= '0;
      step_r      <= STEP_RESET;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      step_r      <= step_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k1_r   <= k1_nxt;
    k2_r   <= k2_nxt;
    out_r  <= out_nxt;
    x_r    <= x_nxt;
    d_r    <= d_nxt;
    acc_r  <= acc_nxt;
    y_r    <= y_nxt;
    e_r    <= e_nxt;
    ge_r   <= ge_nxt;
    prod_r <= prod_nxt;
    w2_r   <= w2_nxt;
  end

  `LMS_ASSERT_NEXT(a_accept_loads, in_valid && in_ready, state_r == ST_LOAD, "accepted beat did not start a load")
  `LMS_ASSERT_NOW(a_pipe_in_pass, s2_v_r, state_r == ST_MAC || state_r == ST_UPD, "tap pipeline active outside a pass")
  `LMS_ASSERT_NEXT(a_done_shows, state_r == ST_DONE && (!out_valid_r || out_ready), out_valid && state_r == ST_IDLE, "finished result not presented")

endmodule

`default_nettype wire
